>>> hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    // Default number of storage slots
    localparam int DEPTH_DEFAULT = 8;

    // Field widths
    localparam int VAL_W = 32;
    localparam int CAP_W = 4;
    localparam int CNT_OUT_W = 4;

    // Capacity register value after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

    // Value reported when no entry exists
    localparam logic [VAL_W-1:0] NONE_VALUE = 32'hFFFF_FFFF;

    // Operation codes carried on the input tuser
    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_REMOVE = 1'b1
    } kind_t;

    // One stored slot: value and its priority number
    typedef struct packed {
        logic signed [VAL_W-1:0] prio;
        logic signed [VAL_W-1:0] value;
    } entry_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS,
        ST_INS_HEAD,
        ST_REM,
        ST_DONE
    } state_t;

endpackage

>>> hw/rtl/spq_mem.sv
// ----------------------------------------------------------------------------
// spq_mem
// Entry store: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module spq_mem #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  spq_pkg::entry_t  wdata,
    input  logic [AW-1:0]    raddr,
    output spq_pkg::entry_t  rdata
);

    spq_pkg::entry_t mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data registered
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer: walks the sorted store one slot per cycle to open or close a gap,
// keeps count and front value, and holds the result register.
// ----------------------------------------------------------------------------
module spq_ctrl #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // input item
    input  logic                        in_valid,
    output logic                        in_ready,
    input  spq_pkg::kind_t              in_kind,
    input  logic [spq_pkg::VAL_W-1:0]   in_value,
    input  logic [spq_pkg::VAL_W-1:0]   in_prio,
    // effective capacity, already limited to DEPTH
    input  logic [CW-1:0]               cap_eff,
    // store ports
    output logic                        mem_we,
    output logic [AW-1:0]               mem_waddr,
    output spq_pkg::entry_t             mem_wdata,
    output logic [AW-1:0]               mem_raddr,
    input  spq_pkg::entry_t             mem_rdata,
    // result register
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        out_ok,
    output logic [spq_pkg::VAL_W-1:0]   out_removed,
    output logic [spq_pkg::VAL_W-1:0]   out_front,
    output logic [CW-1:0]               out_count,
    output logic                        out_empty,
    output logic                        out_full
);

    spq_pkg::state_t             state_reg, state_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [AW-1:0]               idx_reg, idx_next;
    logic [spq_pkg::VAL_W-1:0]   front_reg, front_next;
    logic [spq_pkg::VAL_W-1:0]   val_reg, val_next;
    logic [spq_pkg::VAL_W-1:0]   pri_reg, pri_next;
    logic                        ok_reg, ok_next;
    logic [spq_pkg::VAL_W-1:0]   removed_reg, removed_next;

    logic                        ovalid_reg, ovalid_next;
    logic                        ook_reg, ook_next;
    logic [spq_pkg::VAL_W-1:0]   orem_reg, orem_next;
    logic [spq_pkg::VAL_W-1:0]   ofront_reg, ofront_next;
    logic [CW-1:0]               ocount_reg, ocount_next;
    logic                        oempty_reg, oempty_next;
    logic                        ofull_reg, ofull_next;

    logic                        out_free;
    logic [CW-1:0]               idx_ext;
    spq_pkg::entry_t             new_entry;

    assign out_free  = !ovalid_reg || out_ready;
    assign idx_ext   = CW'(idx_reg);
    assign new_entry = '{prio: $signed(pri_reg), value: $signed(val_reg)};

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= spq_pkg::ST_IDLE;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        front_reg   <= front_next;
        val_reg     <= val_next;
        pri_reg     <= pri_next;
        ok_reg      <= ok_next;
        removed_reg <= removed_next;
        ook_reg     <= ook_next;
        orem_reg    <= orem_next;
        ofront_reg  <= ofront_next;
        ocount_reg  <= ocount_next;
        oempty_reg  <= oempty_next;
        ofull_reg   <= ofull_next;
    end

    // Next state and store accesses
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        front_next   = front_reg;
        val_next     = val_reg;
        pri_next     = pri_reg;
        ok_next      = ok_reg;
        removed_next = removed_reg;
        ovalid_next  = ovalid_reg && !out_ready;
        ook_next     = ook_reg;
        orem_next    = orem_reg;
        ofront_next  = ofront_reg;
        ocount_next  = ocount_reg;
        oempty_next  = oempty_reg;
        ofull_next   = ofull_reg;
        mem_we       = 1'b0;
        mem_waddr    = idx_reg;
        mem_wdata    = new_entry;
        mem_raddr    = '0;
        in_ready     = 1'b0;

        unique case (state_reg)
            spq_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    val_next     = in_value;
                    pri_next     = in_prio;
                    removed_next = spq_pkg::NONE_VALUE;
                    ok_next      = 1'b0;
                    state_next   = spq_pkg::ST_DONE;
                    if (in_kind == spq_pkg::KIND_INSERT)
                    begin
                        if (count_reg < cap_eff)
                        begin
                            ok_next = 1'b1;
                            if (count_reg == '0)
                            begin
                                // empty queue: new entry goes straight to the front
                                mem_we     = 1'b1;
                                mem_waddr  = '0;
                                mem_wdata  = '{prio: $signed(in_prio),
                                               value: $signed(in_value)};
                                front_next = in_value;
                                count_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                // scan from the tail toward the front
                                mem_raddr  = AW'(count_reg - CW'(1));
                                idx_next   = AW'(count_reg);
                                state_next = spq_pkg::ST_INS;
                            end
                        end
                    end
                    else if (count_reg != '0)
                    begin
                        ok_next      = 1'b1;
                        removed_next = front_reg;
                        if (count_reg == CW'(1))
                        begin
                            count_next = '0;
                        end
                        else
                        begin
                            // pull entries forward starting at slot 1
                            mem_raddr  = AW'(1);
                            idx_next   = AW'(1);
                            state_next = spq_pkg::ST_REM;
                        end
                    end
                end
            end

            spq_pkg::ST_INS:
            begin
                // mem_rdata holds slot idx-1
                if (mem_rdata.prio > $signed(pri_reg))
                begin
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata;
                    idx_next  = idx_reg - AW'(1);
                    mem_raddr = idx_reg - AW'(2);
                    if (idx_reg == AW'(1))
                    begin
                        state_next = spq_pkg::ST_INS_HEAD;
                    end
                end
                else
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + CW'(1);
                    state_next = spq_pkg::ST_DONE;
                end
            end

            spq_pkg::ST_INS_HEAD:
            begin
                // every stored entry ranks behind the new one
                mem_we     = 1'b1;
                front_next = val_reg;
                count_next = count_reg + CW'(1);
                state_next = spq_pkg::ST_DONE;
            end

            spq_pkg::ST_REM:
            begin
                // mem_rdata holds slot idx, move it to idx-1
                mem_we    = 1'b1;
                mem_waddr = idx_reg - AW'(1);
                mem_wdata = mem_rdata;
                if (idx_reg == AW'(1))
                begin
                    front_next = mem_rdata.value;
                end
                if ((idx_ext + CW'(1)) < count_reg)
                begin
                    mem_raddr = idx_reg + AW'(1);
                    idx_next  = idx_reg + AW'(1);
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = spq_pkg::ST_DONE;
                end
            end

            spq_pkg::ST_DONE:
            begin
                // hand the status to the result register once it is free
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ook_next    = ok_reg;
                    orem_next   = removed_reg;
                    ofront_next = (count_reg == '0) ? spq_pkg::NONE_VALUE : front_reg;
                    ocount_next = count_reg;
                    oempty_next = (count_reg == '0);
                    ofull_next  = (count_reg >= cap_eff);
                    state_next  = spq_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = spq_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid   = ovalid_reg;
    assign out_ok      = ook_reg;
    assign out_removed = orem_reg;
    assign out_front   = ofront_reg;
    assign out_count   = ocount_reg;
    assign out_empty   = oempty_reg;
    assign out_full    = ofull_reg;

endmodule

>>> hw/rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept as a sorted list in a synchronous store.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  s_axis   | in        | tuser: kind; tdata: item_value, item_priority
//  m_axis   | out       | tuser: ok; tdata: removed_value, front_value,
//           |           |        count, is_empty, is_full
//  cfg      | in        | cfg_wdata: capacity
//
//  One item at a time. An insert into a nonempty queue walks from the tail
//  and shifts each entry that ranks behind the new one a slot back; a
//  remove shifts every remaining entry a slot toward the front. The store
//  moves one slot per cycle through its single read and single write port.
//  Reset clears count and result valid; the store needs no clearing pass.
//  A result waiting on m_tready does not block the next input transfer; the
//  item after it stalls only at its own result hand-off.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // [31:0] item_value, [63:32] item_priority
    input  logic         s_tuser,   // [0] kind
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,   // [31:0] removed_value, [63:32] front_value,
                                    // [67:64] count, [68] is_empty, [69] is_full
    output logic         m_tuser,   // [0] ok
    // capacity register
    input  logic         cfg_we,
    input  logic [3:0]   cfg_wdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = CW + spq_pkg::CAP_W;

    logic [spq_pkg::CAP_W-1:0]   cap_reg;
    logic [XW-1:0]               cap_ext;
    logic [CW-1:0]               cap_eff;

    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [AW-1:0]               mem_raddr;
    spq_pkg::entry_t             mem_wdata;
    spq_pkg::entry_t             mem_rdata;

    logic                        out_ok;
    logic [spq_pkg::VAL_W-1:0]   out_removed;
    logic [spq_pkg::VAL_W-1:0]   out_front;
    logic [CW-1:0]               out_count;
    logic                        out_empty;
    logic                        out_full;
    logic [XW-1:0]               count_ext;

    // Capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= spq_pkg::CAP_RESET;
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_wdata;
        end
    end

    // Capacity limited to the number of slots
    assign cap_ext = XW'(cap_reg);
    assign cap_eff = (cap_ext > XW'(DEPTH)) ? CW'(DEPTH) : cap_ext[CW-1:0];

    spq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    spq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_kind     (spq_pkg::kind_t'(s_tuser)),
        .in_value    (s_tdata[31:0]),
        .in_prio     (s_tdata[63:32]),
        .cap_eff     (cap_eff),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_ok      (out_ok),
        .out_removed (out_removed),
        .out_front   (out_front),
        .out_count   (out_count),
        .out_empty   (out_empty),
        .out_full    (out_full)
    );

    // Result packing; count keeps its low four bits
    assign count_ext = XW'(out_count);
    assign m_tuser   = out_ok;
    assign m_tdata   = {2'b00, out_full, out_empty,
                        count_ext[spq_pkg::CNT_OUT_W-1:0], out_front, out_removed};

endmodule

>>> hw/rtl/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks on the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [71:0]  m_tdata,
    input  logic         m_tuser
);

    // Stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // One item in flight: ready drops after an input transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in flight");

    // A failed operation only happens on an empty or full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[68] || m_tdata[69])
        else $error("failed result with room and entries");

    // Empty queue reports no front and zero count
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[68] |-> m_tdata[63:32] == 32'hFFFF_FFFF
                                    && m_tdata[67:64] == 4'd0)
        else $error("empty flag disagrees with front or count");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> test/spq_result_checker.sv
// ----------------------------------------------------------------------------
// spq_result_checker
// Watches the input, result and capacity ports of the sorted priority queue.
// It keeps its own sorted copy of the queue, predicts one result per accepted
// input transfer, and compares every result transfer field by field with the
// oldest prediction still waiting.
// ----------------------------------------------------------------------------
module spq_result_checker #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [63:0]  s_tdata,   // [31:0] item_value, [63:32] item_priority
    input  logic         s_tuser,   // [0] kind
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [71:0]  m_tdata,   // [31:0] removed_value, [63:32] front_value,
                                    // [67:64] count, [68] is_empty, [69] is_full
    input  logic         m_tuser,   // [0] ok
    input  logic         cfg_we,
    input  logic [3:0]   cfg_wdata,
    output int           fail_count,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        ok;
        logic [31:0] removed_value;
        logic [31:0] front_value;
        logic [3:0]  count;
        logic        is_empty;
        logic        is_full;
    } spq_result_t;

    // Shadow copy of the queue, slot 0 at the front
    logic        [31:0] slot_value [DEPTH];
    logic signed [31:0] slot_prio  [DEPTH];
    int unsigned        stored;
    logic [3:0]         capacity;

    spq_result_t awaited_results [$];

    // Applies one operation to the shadow queue and returns its result
    function automatic spq_result_t queue_step(logic kind_bit, logic [31:0] val,
                                               logic signed [31:0] prio);
        spq_result_t res;
        int unsigned limit;
        int unsigned pos;

        limit = (capacity > DEPTH) ? DEPTH : capacity;
        res.ok = 1'b0;
        res.removed_value = spq_pkg::NONE_VALUE;

        if (spq_pkg::kind_t'(kind_bit) == spq_pkg::KIND_INSERT)
        begin
            if (stored < limit)
            begin
                // land after every entry with a priority number <= ours
                pos = 0;
                while (pos < stored && slot_prio[pos] <= prio)
                    pos++;
                for (int i = stored; i > pos; i--)
                begin
                    slot_value[i] = slot_value[i-1];
                    slot_prio[i]  = slot_prio[i-1];
                end
                slot_value[pos] = val;
                slot_prio[pos]  = prio;
                stored++;
                res.ok = 1'b1;
            end
        end
        else if (stored > 0)
        begin
            res.removed_value = slot_value[0];
            for (int i = 1; i < stored; i++)
            begin
                slot_value[i-1] = slot_value[i];
                slot_prio[i-1]  = slot_prio[i];
            end
            stored--;
            res.ok = 1'b1;
        end

        res.front_value = (stored > 0) ? slot_value[0] : spq_pkg::NONE_VALUE;
        res.count       = stored[3:0];
        res.is_empty    = (stored == 0);
        res.is_full     = (stored >= limit);
        return res;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Per-edge bookkeeping: config writes, result compare, new predictions
    always @(posedge clk or negedge rst_n)
    begin
        spq_result_t want;
        spq_result_t got;
        if (!rst_n)
        begin
            stored     = 0;
            capacity   = spq_pkg::CAP_RESET;
            fail_count = 0;
            awaited_results.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
                capacity = cfg_wdata;

            // a result here always belongs to an earlier input transfer
            if (m_tvalid && m_tready)
            begin
                got.ok            = m_tuser;
                got.removed_value = m_tdata[31:0];
                got.front_value   = m_tdata[63:32];
                got.count         = m_tdata[67:64];
                got.is_empty      = m_tdata[68];
                got.is_full       = m_tdata[69];
                if (awaited_results.size() == 0)
                begin
                    $error("result transfer with no prediction waiting");
                    fail_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("ok", want.ok, got.ok);
                    check_field("removed_value", want.removed_value, got.removed_value);
                    check_field("front_value", want.front_value, got.front_value);
                    check_field("count", want.count, got.count);
                    check_field("is_empty", want.is_empty, got.is_empty);
                    check_field("is_full", want.is_full, got.is_full);
                end
            end

            if (s_tvalid && s_tready)
                awaited_results.push_back(queue_step(s_tuser, s_tdata[31:0], s_tdata[63:32]));

            pending <= awaited_results.size();
        end
    end

endmodule

>>> test/tb_sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue
// Stimulus and verdict for the sorted priority queue. A directed opening
// covers empty removes, extreme values and priorities, ties, refused inserts
// and a capacity lowered under the count; random phases then sweep capacity
// settings from zero to above the depth with bursty input and a stalling
// receiver. Checking is done by spq_result_checker.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT      = 2000;   // cycles with no transfer at all
    localparam int SETTLE_CYCLES   = 16;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int HOLD_START      = 2000;
    localparam int HOLD_CYCLES     = 400;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [63:0]  s_tdata   = '0;   // [31:0] item_value, [63:32] item_priority
    logic         s_tuser   = 1'b0; // [0] kind
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [71:0]  m_tdata;          // [31:0] removed_value, [63:32] front_value,
                                    // [67:64] count, [68] is_empty, [69] is_full
    logic         m_tuser;          // [0] ok
    logic         cfg_we    = 1'b0;
    logic [3:0]   cfg_wdata = '0;

    int fail_count;
    int pending;
    int burst_left = 0;
    int idle_cycles = 0;

    sorted_priority_queue u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    spq_result_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // One input transfer; opens a new burst with a random gap when due
    task automatic send_item(spq_pkg::kind_t kind, logic [31:0] val, logic [31:0] prio);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {prio, val};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Stop offering, wait for every predicted result, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(logic [3:0] cap);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly narrow priorities so ties are common, plus extremes and full range
    function automatic logic [31:0] pick_priority();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return $urandom_range(0, 7) - 3;
        else if (sel < 7)
        begin
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom();
    endfunction

    // Main sequence
    initial
    begin
        logic [3:0] phase_caps [12];
        int ins_pct;

        phase_caps = '{4'd8, 4'd3, 4'd1, 4'd15, 4'd0, 4'd5,
                       4'd9, 4'd2, 4'd8, 4'd6, 4'd7, 4'd4};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty remove, extremes, ties, fill up at reset capacity
        send_item(spq_pkg::KIND_REMOVE, $urandom(), $urandom());
        send_item(spq_pkg::KIND_INSERT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(spq_pkg::KIND_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(spq_pkg::KIND_INSERT, 32'h0000_0000, 32'h0000_0000);
        send_item(spq_pkg::KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(spq_pkg::KIND_INSERT, 32'd5, 32'h0000_0000);
        send_item(spq_pkg::KIND_INSERT, 32'd6, 32'h0000_0000);
        send_item(spq_pkg::KIND_INSERT, 32'd7, 32'h7FFF_FFFF);
        send_item(spq_pkg::KIND_INSERT, 32'd8, 32'h8000_0000);
        // queue is full now: refused insert
        send_item(spq_pkg::KIND_INSERT, 32'd9, 32'h0000_0000);
        repeat (8) send_item(spq_pkg::KIND_REMOVE, $urandom(), $urandom());
        send_item(spq_pkg::KIND_REMOVE, $urandom(), $urandom());

        // capacity lowered under the count, then zero
        repeat (4) send_item(spq_pkg::KIND_INSERT, $urandom(), pick_priority());
        drain();
        write_capacity(4'd2);
        send_item(spq_pkg::KIND_INSERT, $urandom(), pick_priority());
        send_item(spq_pkg::KIND_REMOVE, $urandom(), $urandom());
        drain();
        write_capacity(4'd0);
        send_item(spq_pkg::KIND_INSERT, $urandom(), pick_priority());
        send_item(spq_pkg::KIND_REMOVE, $urandom(), $urandom());
        drain();

        // random phases over a spread of capacity settings
        foreach (phase_caps[ph])
        begin
            write_capacity(phase_caps[ph]);
            ins_pct = 55;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // swing between filling and emptying
                if (n % 30 == 0)
                begin
                    case ($urandom_range(0, 2))
                        0:       ins_pct = 25;
                        1:       ins_pct = 55;
                        default: ins_pct = 85;
                    endcase
                end
                send_item(($urandom_range(0, 99) < ins_pct) ? spq_pkg::KIND_INSERT
                                                            : spq_pkg::KIND_REMOVE,
                          $urandom(), pick_priority());
            end
            drain();
        end

        if (fail_count == 0)
            $display("** sorted_priority_queue: PASSED **");
        else
            $display("** sorted_priority_queue: FAILED **");
        $finish;
    end

    // Receiver: stretches of always-ready, random and sparse patterns,
    // plus one long hold-off while the sender keeps offering
    initial
    begin
        int cyc;
        int stretch_left;
        int mode;
        bit held_off;

        cyc = 0;
        stretch_left = 0;
        mode = 0;
        held_off = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (!held_off && cyc >= HOLD_START && s_tvalid)
            begin
                held_off = 1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (stretch_left == 0)
                begin
                    mode = $urandom_range(0, 2);
                    stretch_left = $urandom_range(10, 80);
                end
                stretch_left--;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= $urandom_range(0, 1);
                    default: m_tready <= (cyc % 4 == 0);
                endcase
            end
        end
    end

    // Watchdog on cycles with no transfer on either stream
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("** sorted_priority_queue: FAILED **");
                $finish;
            end
        end
    end

endmodule
